@@ hdl/osa_ed_pkg.sv @@
`timescale 1ns / 1ps

package osa_ed_pkg;

  // character and result field widths
  localparam int CHAR_W   = 8;
  localparam int DIST_W   = 6;
  localparam int DIST_MAX = 63;

  // item kinds carried on in_tuser
  typedef enum logic [1:0] {
    OP_FIRST  = 2'd0,
    OP_SECOND = 2'd1,
    OP_FINISH = 2'd2
  } opcode_t;

  // control that travels with one row of the wavefront
  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } wave_ctl_t;

endpackage

@@ hdl/osa_ed_ram.sv @@
`timescale 1ns / 1ps

module osa_ed_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

@@ hdl/osa_ed_cell.sv @@
`timescale 1ns / 1ps

module osa_ed_cell #(
  parameter int DW  = 6,
  parameter int IDX = 1
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      init,
  input  logic [DW-1:0]             m_len,
  input  logic                      load_b,
  input  logic [osa_ed_pkg::CHAR_W-1:0] load_char,
  input  osa_ed_pkg::wave_ctl_t     left_ctl,
  input  logic [DW-1:0]             left_cur,
  input  logic [DW-1:0]             left_prev,
  input  logic [DW-1:0]             left_diagp,
  input  logic [osa_ed_pkg::CHAR_W-1:0] left_a,
  input  logic [osa_ed_pkg::CHAR_W-1:0] left_ap,
  input  logic [osa_ed_pkg::CHAR_W-1:0] left_b,
  output osa_ed_pkg::wave_ctl_t     ctl,
  output logic [DW-1:0]             cur,
  output logic [DW-1:0]             prev,
  output logic [DW-1:0]             diagp,
  output logic [osa_ed_pkg::CHAR_W-1:0] a,
  output logic [osa_ed_pkg::CHAR_W-1:0] ap,
  output logic [osa_ed_pkg::CHAR_W-1:0] b
);

  osa_ed_pkg::wave_ctl_t          ctl_r;
  logic [DW-1:0]                  cur_r, prev_r, diag_r, diagp_r;
  logic [DW-1:0]                  cur_nxt;
  logic [osa_ed_pkg::CHAR_W-1:0]  a_r, ap_r, b_r;
  logic                           active;
  logic                           swap_ok;
  logic [DW:0]                    up_v, left_v, sub_v, swap_v, best2, best3, best4;

  assign active = (m_len >= DW'(IDX));

  // recurrence for one matrix entry, one bit wider so the +1 cannot wrap
  always_comb begin
    up_v    = {1'b0, cur_r} + (DW+1)'(1);
    left_v  = {1'b0, left_cur} + (DW+1)'(1);
    sub_v   = {1'b0, left_prev} + (DW+1)'((left_a == b_r) ? 0 : 1);
    swap_v  = {1'b0, left_diagp} + (DW+1)'(1);
    swap_ok = (IDX > 1) && !left_ctl.first && (left_a == left_b) && (left_ap == b_r);
    best2   = (up_v < left_v) ? up_v : left_v;
    best3   = (sub_v < best2) ? sub_v : best2;
    best4   = (swap_ok && (swap_v < best3)) ? swap_v : best3;
    // columns past the second string just forward the left value to the end of the chain
    cur_nxt = active ? best4[DW-1:0] : left_cur;
  end

  // wave control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (init) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= left_ctl;
    end
  end

  // column values: row zero is the column index
  always_ff @(posedge clk) begin
    if (init) begin
      cur_r <= DW'(IDX);
    end else if (left_ctl.valid) begin
      cur_r   <= cur_nxt;
      prev_r  <= cur_r;
      diag_r  <= left_prev;
      diagp_r <= diag_r;
      a_r     <= left_a;
      ap_r    <= left_ap;
    end
  end

  // second string character held by this column
  always_ff @(posedge clk) begin
    if (load_b) begin
      b_r <= load_char;
    end
  end

  assign ctl   = ctl_r;
  assign cur   = cur_r;
  assign prev  = prev_r;
  assign diagp = diagp_r;
  assign a     = a_r;
  assign ap    = ap_r;
  assign b     = b_r;

endmodule

@@ hdl/osa_edit_distance.sv @@
`timescale 1ns / 1ps

// Optimal string alignment (restricted Damerau-Levenshtein) distance unit.
// Items on in_* append a byte to the first or second string (kind on in_tuser)
// or finish; a finish returns one item with the distance on out_tdata and the
// dropped-character flag on out_tuser, then clears both strings. On a finish,
// the rows of the matrix, one per first-string character read from a RAM, run
// as a wavefront through a chain of MAX_LEN column cells that hold the second
// string, and the answer leaves the last cell. With an empty first string the
// result is the second string's length and no wavefront runs. Appends are taken
// while a result waits on the output register. Characters past MAX_LEN are
// dropped.
module osa_edit_distance #(
  parameter int MAX_LEN = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] character
  input  logic [1:0]  in_tuser,   // [1:0] opcode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [5:0] distance, [7:6] zero
  output logic        out_tuser   // [0] overflow
);

  localparam int DW = $clog2(MAX_LEN + 1);
  localparam int AW = $clog2(MAX_LEN);
  localparam int CW = osa_ed_pkg::CHAR_W;

  typedef enum logic [1:0] {S_IDLE, S_RUN, S_DONE} state_t;

  state_t                  state_r;
  logic [DW-1:0]           first_len_r, second_len_r;
  logic                    drop_r;
  logic [DW-1:0]           rd_idx_r;
  logic                    issue_r;
  logic [CW-1:0]           ap_char_r;
  logic [DW-1:0]           res_r;
  logic                    out_valid_r;
  logic [osa_ed_pkg::DIST_W-1:0] out_dist_r;
  logic                    out_ovf_r;

  logic                    in_acc;
  logic                    is_first, is_second, is_finish;
  logic                    wr_first, init_run, do_issue;
  logic [CW-1:0]           ram_q;
  logic [osa_ed_pkg::DIST_W-1:0] res_sat;
  logic                    wave_done;

  osa_ed_pkg::wave_ctl_t   ctl_w   [MAX_LEN+1];
  logic [DW-1:0]           cur_w   [MAX_LEN+1];
  logic [DW-1:0]           prev_w  [MAX_LEN+1];
  logic [DW-1:0]           diagp_w [MAX_LEN+1];
  logic [CW-1:0]           a_w     [MAX_LEN+1];
  logic [CW-1:0]           ap_w    [MAX_LEN+1];
  logic [CW-1:0]           b_w     [MAX_LEN+1];

  // input decode
  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign is_first  = (in_tuser == osa_ed_pkg::OP_FIRST);
  assign is_second = (in_tuser == osa_ed_pkg::OP_SECOND);
  assign is_finish = (in_tuser == osa_ed_pkg::OP_FINISH);
  assign wr_first  = in_acc && is_first && (first_len_r < DW'(MAX_LEN));
  assign init_run  = in_acc && is_finish;
  assign do_issue  = (state_r == S_RUN) && (rd_idx_r < first_len_r);

  // first string store
  osa_ed_ram #(
    .WIDTH (CW),
    .DEPTH (MAX_LEN)
  ) u_first_ram (
    .clk     (clk),
    .wr_en   (wr_first),
    .wr_addr (first_len_r[AW-1:0]),
    .wr_data (in_tdata[CW-1:0]),
    .rd_addr (rd_idx_r[AW-1:0]),
    .rd_data (ram_q)
  );

  // column zero of the matrix feeds the first cell
  always_comb begin
    ctl_w[0].valid = issue_r;
    ctl_w[0].first = (rd_idx_r == DW'(1));
    ctl_w[0].last  = (rd_idx_r == first_len_r);
    cur_w[0]       = rd_idx_r;
    prev_w[0]      = rd_idx_r - DW'(1);
    diagp_w[0]     = '0;
    a_w[0]         = ram_q;
    ap_w[0]        = ap_char_r;
    b_w[0]         = '0;
  end

  // chain of column cells
  for (genvar g = 1; g <= MAX_LEN; g++) begin : g_cell
    logic ld_b;
    assign ld_b = in_acc && is_second && (second_len_r == DW'(g - 1));

    osa_ed_cell #(
      .DW  (DW),
      .IDX (g)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .init       (init_run),
      .m_len      (second_len_r),
      .load_b     (ld_b),
      .load_char  (in_tdata[CW-1:0]),
      .left_ctl   (ctl_w[g-1]),
      .left_cur   (cur_w[g-1]),
      .left_prev  (prev_w[g-1]),
      .left_diagp (diagp_w[g-1]),
      .left_a     (a_w[g-1]),
      .left_ap    (ap_w[g-1]),
      .left_b     (b_w[g-1]),
      .ctl        (ctl_w[g]),
      .cur        (cur_w[g]),
      .prev       (prev_w[g]),
      .diagp      (diagp_w[g]),
      .a          (a_w[g]),
      .ap         (ap_w[g]),
      .b          (b_w[g])
    );
  end

  assign wave_done = ctl_w[MAX_LEN].valid && ctl_w[MAX_LEN].last;

  // clamp to the result field
  assign res_sat = (32'(res_r) > 32'(osa_ed_pkg::DIST_MAX))
                 ? osa_ed_pkg::DIST_W'(osa_ed_pkg::DIST_MAX)
                 : osa_ed_pkg::DIST_W'(res_r);

  // previous first-string character for the swap check
  always_ff @(posedge clk) begin
    if (issue_r) begin
      ap_char_r <= ram_q;
    end
  end

  // control, string lengths and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      first_len_r  <= '0;
      second_len_r <= '0;
      drop_r       <= 1'b0;
      rd_idx_r     <= '0;
      issue_r      <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      issue_r <= do_issue;
      if (do_issue) begin
        rd_idx_r <= rd_idx_r + DW'(1);
      end
      // the done state reloads the output register itself
      if (out_valid_r && out_tready && (state_r != S_DONE)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            if (is_first) begin
              if (first_len_r < DW'(MAX_LEN)) begin
                first_len_r <= first_len_r + DW'(1);
              end else begin
                drop_r <= 1'b1;
              end
            end else if (is_second) begin
              if (second_len_r < DW'(MAX_LEN)) begin
                second_len_r <= second_len_r + DW'(1);
              end else begin
                drop_r <= 1'b1;
              end
            end else if (is_finish) begin
              rd_idx_r <= '0;
              if (first_len_r == '0) begin
                res_r   <= second_len_r;
                state_r <= S_DONE;
              end else begin
                state_r <= S_RUN;
              end
            end
          end
        end
        S_RUN: begin
          if (wave_done) begin
            res_r   <= cur_w[MAX_LEN];
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r  <= 1'b1;
            out_dist_r   <= res_sat;
            out_ovf_r    <= drop_r;
            first_len_r  <= '0;
            second_len_r <= '0;
            drop_r       <= 1'b0;
            rd_idx_r     <= '0;
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = 8'(out_dist_r);
  assign out_tuser  = out_ovf_r;

  // string lengths never pass the capacity
  a_len_cap: assert property (@(posedge clk) disable iff (!rst_n)
    (first_len_r <= DW'(MAX_LEN)) && (second_len_r <= DW'(MAX_LEN)))
    else $error("string length above capacity");

  // row reads never run past the first string
  a_rd_bound: assert property (@(posedge clk) disable iff (!rst_n)
    rd_idx_r <= first_len_r)
    else $error("row index past first string");

  // the final row only leaves the chain while a finish is running
  a_wave_state: assert property (@(posedge clk) disable iff (!rst_n)
    wave_done |-> (state_r == S_RUN))
    else $error("wavefront finished outside a run");

  // the distance never exceeds the longer string
  a_dist_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE) |->
      ((res_r <= first_len_r) || (res_r <= second_len_r)))
    else $error("distance above longer string length");

endmodule

@@ test/tb.sv @@
`timescale 1ns / 1ps

module tb;

  localparam int MAX_LEN = 32;
  localparam int ITEMS = 950;
  localparam int DRAIN = 2 * MAX_LEN + 20;
  localparam int STALL_LIMIT = 4000;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct {
    logic [osa_ed_pkg::DIST_W-1:0] distance;
    logic                          overflow;
  } dist_result_t;

  logic       clk;
  logic       rst_n;
  logic       in_tvalid;
  logic       in_tready;
  logic [7:0] in_tdata;   // [7:0] character
  logic [1:0] in_tuser;   // [1:0] opcode
  logic       out_tvalid;
  logic       out_tready;
  logic [7:0] out_tdata;  // [5:0] distance, [7:6] zero
  logic       out_tuser;  // [0] overflow

  // shadow copy of the two strings and the dropped flag
  logic [7:0] first_str[MAX_LEN];
  logic [7:0] second_str[MAX_LEN];
  int         first_len;
  int         second_len;
  bit         dropped;

  dist_result_t pending_distances[$];

  bit calm;
  int sent_items;
  int append_count;
  int finish_count;
  int ignored_count;
  int checked_count;
  int overflow_count;
  int mismatch_count;
  int idle_cycles;

  osa_edit_distance #(
    .MAX_LEN(MAX_LEN)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // mostly short gaps, a few long ones, none while calm
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // restricted damerau-levenshtein over the shadow strings, three rolling rows
  function automatic logic [osa_ed_pkg::DIST_W-1:0] osa_cost();
    int prev2[MAX_LEN+1];
    int prev[MAX_LEN+1];
    int cur[MAX_LEN+1];
    int i;
    int j;
    int v;
    for (j = 0; j <= second_len; j++) begin
      prev[j] = j;
      prev2[j] = 0;
    end
    for (i = 1; i <= first_len; i++) begin
      cur[0] = i;
      for (j = 1; j <= second_len; j++) begin
        v = prev[j-1] + ((first_str[i-1] == second_str[j-1]) ? 0 : 1);
        if (prev[j] + 1 < v) v = prev[j] + 1;
        if (cur[j-1] + 1 < v) v = cur[j-1] + 1;
        if (i > 1 && j > 1 && first_str[i-1] == second_str[j-2] &&
            first_str[i-2] == second_str[j-1] && prev2[j-2] + 1 < v)
          v = prev2[j-2] + 1;
        cur[j] = v;
      end
      prev2 = prev;
      prev = cur;
    end
    v = prev[second_len];
    if (v > osa_ed_pkg::DIST_MAX) v = osa_ed_pkg::DIST_MAX;
    return v[osa_ed_pkg::DIST_W-1:0];
  endfunction

  // update the shadow state for one accepted item
  function automatic void apply_item(logic [1:0] op, logic [7:0] ch);
    dist_result_t res;
    case (op)
      osa_ed_pkg::OP_FIRST: begin
        if (first_len < MAX_LEN) begin
          first_str[first_len] = ch;
          first_len++;
        end else begin
          dropped = 1'b1;
        end
      end
      osa_ed_pkg::OP_SECOND: begin
        if (second_len < MAX_LEN) begin
          second_str[second_len] = ch;
          second_len++;
        end else begin
          dropped = 1'b1;
        end
      end
      osa_ed_pkg::OP_FINISH: begin
        res.distance = osa_cost();
        res.overflow = dropped;
        pending_distances.insert(pending_distances.size(), res);
        first_len = 0;
        second_len = 0;
        dropped = 1'b0;
      end
      default: ;
    endcase
  endfunction

  task automatic send_item(logic [1:0] op, logic [7:0] ch);
    repeat (pick_gap()) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= ch;
    in_tuser  <= op;
    do @(posedge clk); while (!in_tready);
    apply_item(op, ch);
    if (op == OP_UNUSED) begin
      ignored_count++;
    end else begin
      sent_items++;
      if (op == osa_ed_pkg::OP_FINISH) finish_count++;
      else append_count++;
    end
  endtask

  task automatic send_string(logic [1:0] op, string s);
    for (int k = 0; k < s.len(); k++) send_item(op, s[k]);
  endtask

  // both empty, one side empty
  task automatic test_empty_strings();
    send_item(osa_ed_pkg::OP_FINISH, 8'hFF);
    send_string(osa_ed_pkg::OP_FIRST, "ab");
    send_item(osa_ed_pkg::OP_FINISH, 8'h00);
    send_string(osa_ed_pkg::OP_SECOND, "xyz");
    send_item(osa_ed_pkg::OP_FINISH, 8'h5A);
  endtask

  // adjacent swap, restricted swap, substitution of byte extremes
  task automatic test_single_edits();
    send_string(osa_ed_pkg::OP_FIRST, "ca");
    send_string(osa_ed_pkg::OP_SECOND, "ac");
    send_item(osa_ed_pkg::OP_FINISH, 8'h00);
    send_string(osa_ed_pkg::OP_FIRST, "ca");
    send_string(osa_ed_pkg::OP_SECOND, "abc");
    send_item(osa_ed_pkg::OP_FINISH, 8'hFF);
    send_item(osa_ed_pkg::OP_FIRST, 8'h00);
    send_item(osa_ed_pkg::OP_SECOND, 8'hFF);
    send_item(osa_ed_pkg::OP_FINISH, 8'hA5);
  endtask

  // opcode 3 must leave the strings alone
  task automatic test_unused_opcode();
    send_item(osa_ed_pkg::OP_FIRST, 8'hFF);
    send_item(OP_UNUSED, 8'h00);
    send_item(OP_UNUSED, 8'hFF);
    send_item(osa_ed_pkg::OP_SECOND, 8'hFF);
    send_item(osa_ed_pkg::OP_FINISH, 8'h00);
  endtask

  // overfill both strings, then the widest distance without overflow
  task automatic test_string_full();
    for (int k = 0; k < MAX_LEN + 2; k++) send_item(osa_ed_pkg::OP_FIRST, k[7:0]);
    for (int k = 0; k < MAX_LEN + 1; k++)
      send_item(osa_ed_pkg::OP_SECOND, 8'h80 + k[7:0]);
    send_item(osa_ed_pkg::OP_FINISH, 8'h00);
    for (int k = 0; k < MAX_LEN; k++) send_item(osa_ed_pkg::OP_FIRST, 8'hF0 - k[7:0]);
    send_item(osa_ed_pkg::OP_FINISH, 8'hFF);
  endtask

  // pairs of strings: second is mostly the first with a few random edits
  task automatic test_random_pairs();
    logic [7:0] a[$];
    logic [7:0] b[$];
    logic [7:0] base;
    logic [7:0] tmp;
    int n;
    int r;
    int alpha;
    int pos;
    int ia;
    int ib;
    while (sent_items < ITEMS) begin
      calm = ($urandom_range(0, 7) == 0);
      r = $urandom_range(0, 99);
      if (r < 80) n = $urandom_range(0, 6);
      else if (r < 95) n = $urandom_range(7, 20);
      else n = $urandom_range(MAX_LEN - 4, MAX_LEN + 2);
      alpha = ($urandom_range(0, 3) == 0) ? 256 : $urandom_range(2, 4);
      base = 8'($urandom);
      a.delete();
      for (int k = 0; k < n; k++)
        a.insert(a.size(), (alpha == 256) ? 8'($urandom)
                                          : 8'(base + $urandom_range(0, alpha - 1)));
      b = a;
      if ($urandom_range(0, 9) == 0) begin
        // unrelated second string
        b.delete();
        repeat ($urandom_range(0, 8)) b.insert(b.size(), 8'(base + $urandom_range(0, 3)));
      end else begin
        repeat ($urandom_range(0, 3)) begin
          case ($urandom_range(0, 3))
            0: if (b.size() > 0) b[$urandom_range(0, b.size() - 1)] = 8'($urandom);
            1: if (b.size() > 1) begin
              pos = $urandom_range(0, b.size() - 2);
              tmp = b[pos];
              b[pos] = b[pos+1];
              b[pos+1] = tmp;
            end
            2: b.insert($urandom_range(0, b.size()), 8'($urandom));
            default: if (b.size() > 0) b.delete($urandom_range(0, b.size() - 1));
          endcase
        end
      end
      // interleave the two strings, with the odd ignored item mixed in
      ia = 0;
      ib = 0;
      while (ia < a.size() || ib < b.size()) begin
        if ($urandom_range(0, 19) == 0) send_item(OP_UNUSED, 8'($urandom));
        if (ib >= b.size() || (ia < a.size() && $urandom_range(0, 1) == 1)) begin
          send_item(osa_ed_pkg::OP_FIRST, a[ia]);
          ia++;
        end else begin
          send_item(osa_ed_pkg::OP_SECOND, b[ib]);
          ib++;
        end
      end
      send_item(osa_ed_pkg::OP_FINISH, 8'($urandom));
    end
    calm = 1'b0;
  endtask

  // result stall pattern
  initial begin
    int stall;
    stall = 0;
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (stall > 0) begin
        out_tready <= 1'b0;
        stall--;
      end else begin
        out_tready <= 1'b1;
        if ($urandom_range(0, 3) == 0) stall = pick_gap();
      end
    end
  end

  // compare each result with the oldest expected distance
  always @(posedge clk) begin
    dist_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      checked_count++;
      if (out_tuser) overflow_count++;
      if (pending_distances.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result: distance %0d overflow %0b", out_tdata, out_tuser);
      end else begin
        want = pending_distances.pop_front();
        if (out_tdata !== {2'b00, want.distance} || out_tuser !== want.overflow) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: distance exp %0d got %0d, overflow exp %0b got %0b",
                     want.distance, out_tdata, want.overflow, out_tuser);
        end
      end
    end
  end

  // watchdog on cycles with no item moving on either side
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("timeout with %0d results outstanding", pending_distances.size());
        $display("tb failed");
        $finish;
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = 8'h00;
    in_tuser = osa_ed_pkg::OP_FIRST;
    calm = 1'b0;
    first_len = 0;
    second_len = 0;
    dropped = 1'b0;
    sent_items = 0;
    append_count = 0;
    finish_count = 0;
    ignored_count = 0;
    checked_count = 0;
    overflow_count = 0;
    mismatch_count = 0;
    idle_cycles = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_empty_strings();
    test_single_edits();
    test_unused_opcode();
    test_string_full();
    test_random_pairs();

    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_distances.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);

    $display("sent %0d appends, %0d finishes and %0d ignored items",
             append_count, finish_count, ignored_count);
    $display("checked %0d distances, %0d with overflow set, %0d mismatches",
             checked_count, overflow_count, mismatch_count);
    if (mismatch_count == 0 && pending_distances.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
